FILE: rtl/hcbd_pkg.sv
package hcbd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned SizeBits = 32;

  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [SizeBits-1:0] size_t;

  typedef struct packed {
    logic  emit;
    byte_t out_byte;
    logic  end_of_body;
  } result_t;

endpackage

FILE: rtl/hcbd_in_if.sv
interface hcbd_in_if;
  logic                 valid;
  logic                 ready;
  hcbd_pkg::byte_t      in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

FILE: rtl/hcbd_out_if.sv
interface hcbd_out_if;
  logic                 valid;
  logic                 ready;
  hcbd_pkg::byte_t      out_byte;
  logic                 end_of_body;

  modport source (output valid, output out_byte, output end_of_body, input ready);
  modport sink   (input valid, input out_byte, input end_of_body, output ready);
endinterface

FILE: rtl/hcbd_cfg_if.sv
interface hcbd_cfg_if;
  logic valid;
  logic ready;
  logic chunked_mode;

  modport source (output valid, output chunked_mode, input ready);
  modport sink   (input valid, input chunked_mode, output ready);
endinterface

FILE: rtl/hcbd_in_stage.sv
module hcbd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  hcbd_pkg::byte_t byte_i,
  output logic            ready_o,
  input  logic            take_i,
  output logic            valid_o,
  output hcbd_pkg::byte_t byte_o
);

  logic            valid_q;
  logic            valid_d;
  hcbd_pkg::byte_t byte_q;
  logic            load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

FILE: rtl/hcbd_parser.sv
module hcbd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_mode_i,
  input  logic              fire_i,
  input  hcbd_pkg::byte_t   byte_i,
  output hcbd_pkg::result_t res_o
);

  typedef enum logic [1:0] {
    PhSize    = 2'd0,
    PhPayload = 2'd1,
    PhTrailer = 2'd2,
    PhDone    = 2'd3
  } phase_e;

  localparam hcbd_pkg::size_t SizeMax = '1;

  phase_e          phase_q, phase_d;
  hcbd_pkg::size_t accum_q, accum_d;
  hcbd_pkg::size_t left_q, left_d;
  hcbd_pkg::size_t left_dec;
  logic            closed_q, closed_d;
  logic            started_q, started_d;
  logic            trail_q, trail_d;
  logic            mode_q;
  logic            is_hex;
  logic            is_blank;
  logic [3:0]      digit;

  always_comb begin
    is_hex = 1'b1;
    digit  = '0;
    case (byte_i) inside
      [8'h30:8'h39]: digit = 4'(byte_i - 8'h30);
      [8'h61:8'h66]: digit = 4'(byte_i - 8'h57);
      [8'h41:8'h46]: digit = 4'(byte_i - 8'h37);
      default:       is_hex = 1'b0;
    endcase
  end

  assign is_blank = byte_i inside {8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C};
  assign left_dec = (left_q != '0) ? left_q - 1'b1 : '0;

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    left_d    = left_q;
    closed_d  = closed_q;
    started_d = started_q;
    trail_d   = trail_q;
    res_o     = '{emit: 1'b0, out_byte: byte_i, end_of_body: 1'b0};
    if (!mode_q) begin
      res_o.emit = 1'b1;
    end else begin
      case (phase_q)
        PhSize: begin
          if (byte_i == 8'h0A) begin
            if (accum_q == '0) begin
              phase_d = PhDone;
              res_o   = '{emit: 1'b1, out_byte: '0, end_of_body: 1'b1};
            end else begin
              left_d  = accum_q;
              phase_d = PhPayload;
            end
          end else if (!closed_q) begin
            if (is_hex) begin
              started_d = 1'b1;
              if (|accum_q[hcbd_pkg::SizeBits-1 -: 4]) begin
                accum_d = SizeMax;
              end else begin
                accum_d = {accum_q[hcbd_pkg::SizeBits-5:0], digit};
              end
            end else if (!(is_blank && !started_q)) begin
              closed_d = 1'b1;
            end
          end
        end
        PhPayload: begin
          res_o.emit = 1'b1;
          left_d     = left_dec;
          if (left_dec == '0) begin
            phase_d = PhTrailer;
            trail_d = 1'b0;
          end
        end
        PhTrailer: begin
          if (!trail_q) begin
            trail_d = 1'b1;
          end else begin
            trail_d   = 1'b0;
            phase_d   = PhSize;
            accum_d   = '0;
            closed_d  = 1'b0;
            started_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhSize;
      accum_q   <= '0;
      left_q    <= '0;
      closed_q  <= 1'b0;
      started_q <= 1'b0;
      trail_q   <= 1'b0;
      mode_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
      if (fire_i) begin
        phase_q   <= phase_d;
        accum_q   <= accum_d;
        left_q    <= left_d;
        closed_q  <= closed_d;
        started_q <= started_d;
        trail_q   <= trail_d;
      end
    end
  end

  a_eob_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.emit && res_o.end_of_body |=> phase_q == PhDone)
    else $error("end of body did not enter done phase");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> left_q != '0)
    else $error("payload phase with zero bytes left");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q && phase_q == PhDone |-> !res_o.emit)
    else $error("result issued after end of body");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhDone |=> phase_q == PhDone)
    else $error("left done phase without reset");

endmodule

FILE: rtl/hcbd_out_stage.sv
module hcbd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  hcbd_pkg::result_t res_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output hcbd_pkg::byte_t   out_byte_o,
  output logic              end_of_body_o
);

  logic            valid_q;
  logic            valid_d;
  hcbd_pkg::byte_t byte_q;
  logic            eob_q;
  logic            take;

  assign free_o  = !valid_q || ready_i;
  assign take    = load_i && res_i.emit;
  assign valid_d = take || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= res_i.out_byte;
      eob_q  <= res_i.end_of_body;
    end
  end

  assign valid_o       = valid_q;
  assign out_byte_o    = byte_q;
  assign end_of_body_o = eob_q;

endmodule

FILE: rtl/http_chunked_body_decoder.sv
// Each byte is registered in the input register, then its result in the result register;
// a result waits there until the sink is ready, and no new byte is parsed meanwhile.
// Throughput: one byte per cycle while the result register is free; framing bytes count too.
// The result register lets a new byte enter while the previous result waits to be taken.
// Reset (rst_ni low, async): pipeline empty, size-line parse, chunked_mode = 0.
module http_chunked_body_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o,
  hcbd_cfg_if.sink   cfg_i
);

  logic              s1_valid;
  hcbd_pkg::byte_t   s1_byte;
  logic              out_free;
  logic              fire;
  hcbd_pkg::result_t res;

  assign cfg_i.ready = 1'b1;
  assign fire        = s1_valid && out_free;

  hcbd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .byte_i  (in_i.in_byte),
    .ready_o (in_i.ready),
    .take_i  (fire),
    .valid_o (s1_valid),
    .byte_o  (s1_byte)
  );

  hcbd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_mode_i (cfg_i.chunked_mode),
    .fire_i     (fire),
    .byte_i     (s1_byte),
    .res_o      (res)
  );

  hcbd_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire),
    .res_i         (res),
    .free_o        (out_free),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .end_of_body_o (out_o.end_of_body)
  );

endmodule

FILE: sim/tb_http_chunked_body_decoder.sv
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder;

  localparam int unsigned HALF   = 10;
  localparam int unsigned LIMIT  = 200000;
  localparam int unsigned SETTLE = 4;
  localparam int unsigned HOLD   = 80;
  localparam int unsigned N_RAND = 1950;
  localparam int unsigned N_DIR  = 26;

  localparam hcbd_pkg::byte_t LF      = 8'h0A;
  localparam hcbd_pkg::byte_t CR      = 8'h0D;
  localparam hcbd_pkg::byte_t SP      = 8'h20;
  localparam hcbd_pkg::byte_t HT      = 8'h09;
  localparam hcbd_pkg::byte_t VT      = 8'h0B;
  localparam hcbd_pkg::byte_t FF      = 8'h0C;
  localparam hcbd_pkg::byte_t SEMI    = 8'h3B;
  localparam hcbd_pkg::byte_t ZERO_CH = 8'h30;
  localparam hcbd_pkg::byte_t NINE_CH = 8'h39;
  localparam hcbd_pkg::byte_t UC_A    = 8'h41;
  localparam hcbd_pkg::byte_t UC_F    = 8'h46;
  localparam hcbd_pkg::byte_t LC_A    = 8'h61;
  localparam hcbd_pkg::byte_t LC_F    = 8'h66;
  localparam hcbd_pkg::byte_t LC_X    = 8'h78;

  localparam hcbd_pkg::size_t SIZE_SAT  = '1;
  localparam hcbd_pkg::size_t SAT_EDGE  = {4'h0, {(hcbd_pkg::SizeBits - 4){1'b1}}};

  typedef enum logic [1:0] {SIZE_LINE, PAYLOAD, TRAILER, DONE} parse_ph_e;
  typedef enum logic {ST_BYTE, ST_MODE} step_kind_e;

  typedef struct packed {
    hcbd_pkg::byte_t out_byte;
    logic            end_of_body;
  } decoded_t;

  typedef struct packed {
    step_kind_e      kind;
    hcbd_pkg::byte_t data;
    logic            typed;
    decoded_t        given;
  } step_t;

  logic clk;
  logic rst_n;

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();
  hcbd_cfg_if cfg_if ();

  http_chunked_body_decoder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk = 1'b0;
    #HALF;
    clk = 1'b1;
    #HALF;
  end

  // decoder state mirror
  logic            chunked   = 1'b0;
  parse_ph_e       parse_ph  = SIZE_LINE;
  hcbd_pkg::size_t size_acc  = '0;
  hcbd_pkg::size_t remaining = '0;
  logic            num_closed = 1'b0;
  logic            num_seen   = 1'b0;
  logic            crlf_half  = 1'b0;

  decoded_t    decoded_q[$];
  int unsigned mismatches = 0;
  int unsigned sent = 0;
  int unsigned cycles = 0;
  logic        idle_en;
  logic        hold_go;

  step_t dir_plan [0:N_DIR-1] = '{
    '{ST_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b0}},
    '{ST_BYTE, LF,    1'b1, '{LF,    1'b0}},
    '{ST_MODE, 8'h01, 1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, SP,    1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, HT,    1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, VT,    1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, FF,    1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, CR,    1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'h30, 1'b0, '{8'h00, 1'b0}},
    '{ST_MODE, 8'h00, 1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'h80, 1'b1, '{8'h80, 1'b0}},
    '{ST_MODE, 8'h01, 1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'h32, 1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, SEMI,  1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, LC_F,  1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, LF,    1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b0}},
    '{ST_BYTE, CR,    1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, LF,    1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'h31, 1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, LF,    1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'h5A, 1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'h47, 1'b0, '{8'h00, 1'b0}},
    '{ST_BYTE, 8'h80, 1'b0, '{8'h00, 1'b0}}
  };

  function automatic logic decode_byte(input hcbd_pkg::byte_t c, output decoded_t r);
    hcbd_pkg::byte_t off;
    logic [3:0]      nib;
    logic            is_hex;
    logic            blank;
    r = '{out_byte: c, end_of_body: 1'b0};
    if (!chunked) return 1'b1;
    is_hex = 1'b1;
    if (c >= ZERO_CH && c <= NINE_CH) off = c - ZERO_CH;
    else if (c >= LC_A && c <= LC_F) off = c - LC_A + 8'd10;
    else if (c >= UC_A && c <= UC_F) off = c - UC_A + 8'd10;
    else begin
      is_hex = 1'b0;
      off = 8'h00;
    end
    nib = off[3:0];
    blank = (c == SP) || (c == HT) || (c == CR) || (c == VT) || (c == FF);
    case (parse_ph)
      SIZE_LINE: begin
        if (c == LF) begin
          if (size_acc == '0) begin
            parse_ph = DONE;
            r = '{out_byte: 8'h00, end_of_body: 1'b1};
            return 1'b1;
          end
          remaining = size_acc;
          parse_ph = PAYLOAD;
        end else if (!num_closed) begin
          if (is_hex) begin
            num_seen = 1'b1;
            size_acc = (size_acc > SAT_EDGE) ? SIZE_SAT :
                       {size_acc[hcbd_pkg::SizeBits-5:0], nib};
          end else if (!(blank && !num_seen)) begin
            num_closed = 1'b1;
          end
        end
      end
      PAYLOAD: begin
        if (remaining != '0) remaining = remaining - 1'b1;
        if (remaining == '0) begin
          parse_ph = TRAILER;
          crlf_half = 1'b0;
        end
        return 1'b1;
      end
      TRAILER: begin
        if (!crlf_half) begin
          crlf_half = 1'b1;
        end else begin
          crlf_half = 1'b0;
          parse_ph = SIZE_LINE;
          size_acc = '0;
          num_closed = 1'b0;
          num_seen = 1'b0;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic hcbd_pkg::byte_t rand_byte();
    logic [31:0] v;
    v = $urandom;
    return v[7:0];
  endfunction

  function automatic hcbd_pkg::byte_t pick_blank();
    case ($urandom_range(0, 4))
      0: return SP;
      1: return HT;
      2: return CR;
      3: return VT;
      default: return FF;
    endcase
  endfunction

  task automatic put_byte(input hcbd_pkg::byte_t b, input logic typed, input decoded_t given);
    decoded_t r;
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (decode_byte(b, r)) decoded_q.push_back(typed ? given : r);
    sent++;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.chunked_mode <= m;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    chunked = m;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic pass_through();
    set_mode(1'b0);
    repeat ($urandom_range(1, 12)) put_byte(rand_byte(), 1'b0, '0);
    set_mode(1'b1);
  endtask

  task automatic send_chunk(input logic noisy);
    hcbd_pkg::byte_t seq[$];
    int              len;
    int              nd;
    logic [31:0]     lw;
    logic [3:0]      nib;
    hcbd_pkg::byte_t ch;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 300) : $urandom_range(1, 8);
    repeat ($urandom_range(0, 2)) seq.push_back(pick_blank());
    repeat ($urandom_range(0, 2)) seq.push_back(ZERO_CH);
    nd = (len > 255) ? 3 : (len > 15) ? 2 : 1;
    lw = len;
    for (int i = nd - 1; i >= 0; i--) begin
      nib = lw[4*i +: 4];
      if (nib < 4'd10) seq.push_back(ZERO_CH + {4'h0, nib});
      else seq.push_back(($urandom_range(0, 1) ? UC_A : LC_A) + {4'h0, nib} - 8'd10);
    end
    // extension or junk after the digits
    if (noisy || $urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: seq.push_back(SEMI);
        1: seq.push_back(SP);
        2: seq.push_back(CR);
        default: seq.push_back(LC_X);
      endcase
      repeat ($urandom_range(0, 5)) begin
        ch = rand_byte();
        seq.push_back((ch == LF) ? SEMI : ch);
      end
    end
    if ($urandom_range(0, 1) != 0) seq.push_back(CR);
    seq.push_back(LF);
    repeat (len) seq.push_back(rand_byte());
    if (noisy) begin
      seq.push_back(rand_byte());
      seq.push_back(rand_byte());
    end else begin
      seq.push_back(CR);
      seq.push_back(LF);
    end
    foreach (seq[k]) begin
      if ($urandom_range(0, 199) == 0) pass_through();
      put_byte(seq[k], 1'b0, '0);
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD) @(negedge clk);
      end else begin
        out_if.ready <= !(idle_en && $urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin : check_out
    decoded_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction: expected none, actual byte=%h eob=%b",
                 $time, out_if.out_byte, out_if.end_of_body);
      end else begin
        want = decoded_q.pop_front();
        if (want.out_byte !== out_if.out_byte || want.end_of_body !== out_if.end_of_body) begin
          mismatches++;
          $display("%0t: mismatch: expected byte=%h eob=%b, actual byte=%h eob=%b",
                   $time, want.out_byte, want.end_of_body,
                   out_if.out_byte, out_if.end_of_body);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.chunked_mode = 1'b0;
    idle_en = 1'b1;
    hold_go = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_plan[k]) begin
      if (dir_plan[k].kind == ST_MODE) set_mode(dir_plan[k].data[0]);
      else put_byte(dir_plan[k].data, dir_plan[k].typed, dir_plan[k].given);
    end

    // receiver stalls while bytes keep coming
    set_mode(1'b0);
    hold_go = 1'b1;
    repeat (40) put_byte(rand_byte(), 1'b0, '0);
    set_mode(1'b1);

    while (sent < N_DIR + N_RAND) begin
      idle_en = !(sent >= 700 && sent < 1000);
      pick = $urandom_range(0, 99);
      if (pick < 75) send_chunk(1'b0);
      else if (pick < 90) send_chunk(1'b1);
      else pass_through();
    end

    // only one terminal condition fits in a run, since reset is applied once
    idle_en = 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      // nine digits: saturates, a wrapping counter would end the chunk after 5 bytes
      put_byte(8'h31, 1'b0, '0);
      repeat (7) put_byte(ZERO_CH, 1'b0, '0);
      put_byte(8'h35, 1'b0, '0);
      put_byte(LF, 1'b0, '0);
      repeat (40) put_byte(rand_byte(), 1'b0, '0);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          put_byte(ZERO_CH, 1'b0, '0);
          put_byte(CR, 1'b0, '0);
        end
        1: begin
          put_byte(SP, 1'b0, '0);
          put_byte(HT, 1'b0, '0);
        end
        2: begin
          put_byte(ZERO_CH, 1'b0, '0);
          put_byte(SEMI, 1'b0, '0);
          put_byte(LC_F, 1'b0, '0);
        end
        default: ;
      endcase
      put_byte(LF, 1'b0, '0);
      repeat (12) put_byte(rand_byte(), 1'b0, '0);
      set_mode(1'b0);
      repeat (6) put_byte(rand_byte(), 1'b0, '0);
      set_mode(1'b1);
      repeat (6) put_byte(rand_byte(), 1'b0, '0);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/hcbd_pkg.sv
rtl/hcbd_in_if.sv
rtl/hcbd_out_if.sv
rtl/hcbd_cfg_if.sv
rtl/hcbd_in_stage.sv
rtl/hcbd_parser.sv
rtl/hcbd_out_stage.sv
rtl/http_chunked_body_decoder.sv
sim/tb_http_chunked_body_decoder.sv
